[rtl/lrl_pkg.sv]
`default_nettype none

package lrl_pkg;

  localparam int DEPTH     = 8;
  localparam int KEY_BITS  = 16;

  // fixed field widths of the stream items
  localparam int KEY_FIELD_BITS = 16;
  localparam int CAP_BITS       = 4;
  localparam int HPOS_BITS      = 3;
  localparam int OCC_BITS       = 4;

  localparam int POS_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int CMP_BITS = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

  localparam int OUT_RAW_BITS = 1 + HPOS_BITS + 1 + KEY_FIELD_BITS + OCC_BITS;
  localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);

  typedef struct packed {
    logic load_key;
    logic update;
    logic cfg_wr;
  } lrl_cmd_t;

endpackage

`default_nettype wire

[rtl/lrl_ctrl.sv]
`default_nettype none

module lrl_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  output lrl_pkg::lrl_cmd_t   cmd
);
  import lrl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.load_key = 1'b0;
    cmd.update   = 1'b0;
    cmd.cfg_wr   = cfg_valid;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_key = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait here while the previous result is still unread
        if (out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_update_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (state_r == ST_EXEC) && (!out_valid_r || out_tready))
    else $error("update while output register occupied");

  a_update_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("result not presented after update");

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_key |=> (state_r == ST_EXEC) && !in_tready)
    else $error("accepted key not followed by update state");
`endif

endmodule

`default_nettype wire

[rtl/lrl_datapath.sv]
`default_nettype none

module lrl_datapath (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire  lrl_pkg::lrl_cmd_t                cmd,
  input  wire  [lrl_pkg::KEY_FIELD_BITS-1:0]     in_key,
  input  wire  [lrl_pkg::CAP_BITS-1:0]           cfg_capacity,
  output logic [lrl_pkg::OUT_BITS-1:0]           result
);
  import lrl_pkg::*;

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] keys_r [DEPTH];
  logic [KEY_BITS-1:0] keys_nxt [DEPTH];
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [CAP_BITS-1:0] cap_r;
  logic [OUT_BITS-1:0] result_r;

  logic                hit;
  logic [POS_BITS-1:0] hit_pos;
  logic [CMP_BITS-1:0] eff_cap;
  logic                full;
  logic [CNT_BITS-1:0] last_idx;
  logic [CNT_BITS-1:0] upto;
  logic [KEY_BITS-1:0] oldest_key;
  logic                evict;

  // 0 acts as 1, values above the list depth saturate
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (CMP_BITS'(cap_r) > CMP_BITS'(DEPTH)) begin
      eff_cap = CMP_BITS'(DEPTH);
    end else begin
      eff_cap = CMP_BITS'(cap_r);
    end
  end

  assign full       = CMP_BITS'(count_r) >= eff_cap;
  assign last_idx   = count_r - CNT_BITS'(1);
  assign oldest_key = keys_r[last_idx[POS_BITS-1:0]];

  // first match among the valid positions
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((CNT_BITS'(i) < count_r) && (keys_r[i] == key_r)) begin
        hit     = 1'b1;
        hit_pos = POS_BITS'(i);
      end
    end
  end

  assign evict = !hit && full;

  always_comb begin
    if (hit) begin
      upto      = CNT_BITS'(hit_pos);
      count_nxt = count_r;
    end else if (full) begin
      upto      = last_idx;
      count_nxt = count_r;
    end else begin
      upto      = count_r;
      count_nxt = count_r + CNT_BITS'(1);
    end
  end

  always_comb begin
    keys_nxt[0] = key_r;
    for (int i = 1; i < DEPTH; i++) begin
      keys_nxt[i] = (CNT_BITS'(i) <= upto) ? keys_r[i-1] : keys_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= KEY_BITS'(in_key);
    end
    if (cmd.update) begin
      keys_r   <= keys_nxt;
      result_r <= OUT_BITS'({OCC_BITS'(count_nxt),
                             evict ? KEY_FIELD_BITS'(oldest_key) : KEY_FIELD_BITS'(0),
                             evict,
                             hit ? HPOS_BITS'(hit_pos) : HPOS_BITS'(0),
                             hit});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (cmd.update) begin
        count_r <= count_nxt;
      end
      if (cmd.cfg_wr) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  assign result = result_r;

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_BITS'(count_r) <= CMP_BITS'(DEPTH))
    else $error("occupancy above list depth");

  a_count_nonzero_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> count_r != '0)
    else $error("list empty after a reference");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && (hit || evict) |=> $stable(count_r))
    else $error("occupancy changed on hit or eviction");
`endif

endmodule

`default_nettype wire

[rtl/lru_recency_list.sv]
`default_nettype none

// channel  | handshake              | payload
// ---------+------------------------+----------------------------------------------
// in       | in_tvalid / in_tready   | in_tdata[15:0]  key
// out      | out_tvalid / out_tready | out_tdata[31:0] hit, hit_position, evicted,
//          |                        |                 evicted_key, occupancy
// cfg      | cfg_valid / cfg_ready   | cfg_data[3:0]   capacity
//
// an item is taken in order: the key is registered, then comes the parallel compare
// and shift of the recency file; no new key is taken before that update is done
// the result shows in out_tdata the cycle after the update
// the update cycle waits while the output register holds an untaken result
// rst_n (synchronous) empties the list and sets capacity to 8; cfg_ready is always high

module lru_recency_list (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [lrl_pkg::KEY_FIELD_BITS-1:0]  in_tdata,   // key
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // hit, hit_position[2:0], evicted, evicted_key[15:0], occupancy[3:0], zero pad
  output logic [lrl_pkg::OUT_BITS-1:0]        out_tdata,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [lrl_pkg::CAP_BITS-1:0]        cfg_data
);
  import lrl_pkg::*;

  lrl_cmd_t cmd;

  lrl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd)
  );

  lrl_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_key       (in_tdata),
    .cfg_capacity (cfg_data),
    .result       (out_tdata)
  );

endmodule

`default_nettype wire

[test/lru_recency_list_tb.sv]
`default_nettype none

module lru_recency_list_tb;

  import lrl_pkg::*;

  // result fields from the msb down, so the packed value lines up with out_tdata
  typedef struct packed {
    logic [OCC_BITS-1:0]       occ;
    logic [KEY_FIELD_BITS-1:0] ev_key;
    logic                      evicted;
    logic [HPOS_BITS-1:0]      pos;
    logic                      hit;
  } access_result_t;

  localparam int RES_BITS = $bits(access_result_t);

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [KEY_FIELD_BITS-1:0] in_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_BITS-1:0]       out_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CAP_BITS-1:0]       cfg_data;

  // shadow copy of the recency list
  logic [KEY_FIELD_BITS-1:0] shadow_keys [DEPTH];
  int unsigned               shadow_count;
  logic [CAP_BITS-1:0]       shadow_cap;

  access_result_t            pending_results [$];
  logic [KEY_FIELD_BITS-1:0] key_pool [$];
  int                        errors;
  int                        tx_idle_pct;
  int                        rx_idle_pct;
  bit                        long_hold_req;

  lru_recency_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // key
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // hit, hit_position, evicted, evicted_key, occupancy
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // capacity
  );

  always #1 clk = ~clk;

  // shift positions below upto down by one and put key at the front
  function automatic void move_to_front(input int unsigned upto,
                                        input logic [KEY_FIELD_BITS-1:0] key);
    int unsigned i;
    if (upto >= DEPTH) upto = DEPTH - 1;
    for (i = upto; i > 0; i--) shadow_keys[i] = shadow_keys[i-1];
    shadow_keys[0] = key;
  endfunction

  function automatic access_result_t predict_access(input logic [KEY_FIELD_BITS-1:0] key);
    access_result_t r;
    int unsigned    eff_cap;
    int unsigned    n;
    int unsigned    i;
    eff_cap = shadow_cap;
    if (eff_cap == 0) eff_cap = 1;
    if (eff_cap > DEPTH) eff_cap = DEPTH;
    n = shadow_count;
    r = '0;
    for (i = 0; i < n; i++) begin
      if (!r.hit && shadow_keys[i] == key) begin
        r.hit = 1'b1;
        r.pos = HPOS_BITS'(i);
      end
    end
    if (r.hit) begin
      move_to_front(r.pos, key);
    end else if (n >= eff_cap) begin
      // also covers a list left above a lowered capacity: only one entry goes
      r.evicted = 1'b1;
      r.ev_key = shadow_keys[n-1];
      move_to_front(n - 1, key);
    end else begin
      move_to_front(n, key);
      n++;
    end
    shadow_count = n;
    r.occ = OCC_BITS'(n);
    return r;
  endfunction

  task automatic send_key(input logic [KEY_FIELD_BITS-1:0] key);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= key;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_access(key));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_cap = cap;
  endtask

  task automatic fill_key_pool(input int n);
    key_pool.delete();
    repeat (n) key_pool.push_back(KEY_FIELD_BITS'($urandom));
  endtask

  // mostly keys from a small pool so hits are common, some fully random
  task automatic send_random_keys(input int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0)
        send_key(KEY_FIELD_BITS'($urandom));
      else
        send_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
    end
  endtask

  task automatic test_min_capacity();
    write_capacity(4'd1);
    send_key(16'h0000);
    send_key(16'hffff);
    send_key(16'hffff);
    send_key(16'h0000);
  endtask

  // zero acts as a capacity of one
  task automatic test_zero_capacity();
    write_capacity(4'd0);
    send_key(16'h1234);
    send_key(16'h1234);
    send_key(16'hedcb);
  endtask

  // occupancy never shrinks, so capacities are visited in rising order
  task automatic test_growing_capacity();
    int cap;
    for (cap = 2; cap <= 7; cap++) begin
      write_capacity(CAP_BITS'(cap));
      fill_key_pool(cap + 3);
      tx_idle_pct = (cap == 4) ? 0 : 20;
      rx_idle_pct = (cap == 5) ? 0 : 20;
      send_random_keys(160);
    end
  endtask

  // capacity above the list depth saturates; walk a hit down to the oldest slot
  task automatic test_full_list();
    write_capacity(4'd15);
    send_key(16'h0000);
    send_key(16'hffff);
    send_key(16'h8000);
    send_key(16'h7fff);
    send_key(16'h5555);
    send_key(16'haaaa);
    send_key(16'h0001);
    send_key(16'hfffe);
    send_key(16'h0000);
    send_key(16'h0000);
    send_key(16'h7fff);
    send_key(16'h4242);
  endtask

  task automatic test_capacity_below_occupancy();
    write_capacity(4'd3);
    send_key(16'h0f0f);
    send_key(16'hf0f0);
    send_key(16'h0f0f);
    fill_key_pool(10);
    send_random_keys(150);
  endtask

  task automatic test_output_backpressure();
    write_capacity(4'd8);
    fill_key_pool(10);
    tx_idle_pct = 0;
    long_hold_req = 1'b1;
    send_random_keys(30);
    // pause until every result is back
    drain_results();
  endtask

  task automatic test_back_to_back();
    logic [CAP_BITS-1:0] caps [5];
    int                  i;
    caps = '{4'd8, 4'd5, 4'd0, 4'd15, 4'd1};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (i = 0; i < 5; i++) begin
      write_capacity(caps[i]);
      fill_key_pool(11);
      send_random_keys(120);
    end
  endtask

  task automatic report_mismatch(input string what, input longint e, input longint a);
    errors++;
    $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, e, a);
  endtask

  // result side: random stalls, and a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
        long_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    access_result_t got;
    access_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[RES_BITS-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", 0, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", want.hit, got.hit);
        if (got.pos !== want.pos) report_mismatch("hit_position", want.pos, got.pos);
        if (got.evicted !== want.evicted)
          report_mismatch("evicted", want.evicted, got.evicted);
        if (got.ev_key !== want.ev_key)
          report_mismatch("evicted_key", want.ev_key, got.ev_key);
        if (got.occ !== want.occ) report_mismatch("occupancy", want.occ, got.occ);
        if (out_tdata[OUT_BITS-1:RES_BITS] !== '0)
          report_mismatch("pad", 0, out_tdata[OUT_BITS-1:RES_BITS]);
      end
    end
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    long_hold_req = 1'b0;
    shadow_count = 0;
    shadow_cap = CAP_RESET;
    foreach (shadow_keys[i]) shadow_keys[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_min_capacity();
    test_zero_capacity();
    test_growing_capacity();
    test_full_list();
    test_capacity_below_occupancy();
    test_output_backpressure();
    test_back_to_back();

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/lrl_pkg.sv
rtl/lrl_ctrl.sv
rtl/lrl_datapath.sv
rtl/lru_recency_list.sv
test/lru_recency_list_tb.sv
